// File: hw/rtl/pbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbi_pkg;

   // Field formats
   localparam int COORD_WIDTH    = 24;
   localparam int FRAC_BITS      = 16;
   localparam int TS_WIDTH       = 16;
   localparam int GRAV_WIDTH     = 23;
   localparam int REST_WIDTH     = 16;
   localparam int ZB_WIDTH       = 23;
   localparam int CNT_WIDTH      = 8;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 23;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TIME_STEP   = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GRAVITY     = CSR_ADDR_WIDTH'(1);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RESTITUTION = CSR_ADDR_WIDTH'(2);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_Z_BOUND     = CSR_ADDR_WIDTH'(3);

   // Internal widths
   localparam int PROD_WIDTH = COORD_WIDTH + FRAC_BITS + 1;  // coord x unsigned Q0.16
   localparam int STEP_WIDTH = COORD_WIDTH + 1;              // rounded position step
   localparam int WIDE_WIDTH = COORD_WIDTH + FRAC_BITS + 2;  // headroom for sums and clamps
   localparam int GT_WIDTH   = GRAV_WIDTH + TS_WIDTH;        // gravity x time step
   localparam int G_WIDTH    = GT_WIDTH + 1 - FRAC_BITS;     // rounded velocity drop

   localparam int NUM_AXES = 3;
   localparam int AXIS_X   = 0;
   localparam int AXIS_Y   = 1;
   localparam int AXIS_Z   = 2;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(2 ** (FRAC_BITS - 1));
   localparam logic signed [WIDE_WIDTH-1:0] WALL_UNIT  = WIDE_WIDTH'(2 ** FRAC_BITS);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type              pos_x;
      coord_type              pos_y;
      coord_type              pos_z;
      coord_type              vel_x;
      coord_type              vel_y;
      coord_type              vel_z;
      logic [CNT_WIDTH-1:0]   bounces_left;
   } req_type;

   typedef struct packed {
      coord_type              new_pos_x;
      coord_type              new_pos_y;
      coord_type              new_pos_z;
      coord_type              new_vel_x;
      coord_type              new_vel_y;
      coord_type              new_vel_z;
      logic [CNT_WIDTH-1:0]   new_bounces_left;
      logic                   alive;
   } rsp_type;

   typedef struct packed {
      logic [TS_WIDTH-1:0]    time_step;
      logic [GRAV_WIDTH-1:0]  gravity;
      logic [REST_WIDTH-1:0]  restitution;
      logic [ZB_WIDTH-1:0]    z_bound;
   } cfg_type;

   // Particle after integration and wall clamp, waiting for its bounce rounds
   typedef struct packed {
      coord_type [NUM_AXES-1:0] pos;
      coord_type [NUM_AXES-1:0] vel;
      logic [NUM_AXES-1:0]      hit;
      logic [CNT_WIDTH-1:0]     count;
   } work_type;

   localparam cfg_type CFG_RESET = '{
      time_step:   TS_WIDTH'(1092),
      gravity:     GRAV_WIDTH'(642253),
      restitution: REST_WIDTH'(52429),
      z_bound:     ZB_WIDTH'(65536)
   };

   // Saturate to the signed coordinate range
   function automatic coord_type sat_coord(input logic signed [WIDE_WIDTH-1:0] v);
      logic signed [WIDE_WIDTH-1:0] max_w;
      logic signed [WIDE_WIDTH-1:0] min_w;
      max_w = WIDE_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
      min_w = ~max_w;
      if (v > max_w) begin
         return max_w[COORD_WIDTH-1:0];
      end else if (v < min_w) begin
         return min_w[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   // Round half up and drop the fraction bits
   function automatic logic signed [PROD_WIDTH-1:0] rnd_frac(
      input logic signed [PROD_WIDTH-1:0] v
   );
      logic signed [PROD_WIDTH-1:0] t;
      t = v + ROUND_HALF;
      return t >>> FRAC_BITS;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pbi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pbi_front
   import pbi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire req_type  req_data,
   output logic          req_stall,
   input  wire cfg_type  cfg,
   output logic          push_valid,
   output work_type      push_data,
   input  wire logic     q_full
);

   logic front_adv;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;

   req_type                s1_req_ff;
   logic [GT_WIDTH-1:0]    s1_gt_ff;
   logic [GT_WIDTH-1:0]    gt_in;

   coord_type [NUM_AXES-1:0] s2_pos_ff;
   coord_type [NUM_AXES-1:0] s2_vel_ff;
   logic [CNT_WIDTH-1:0]     s2_cnt_ff;
   coord_type [NUM_AXES-1:0] s2_vel_in;

   coord_type [NUM_AXES-1:0] s3_pos_ff;
   coord_type [NUM_AXES-1:0] s3_vel_ff;
   logic [CNT_WIDTH-1:0]     s3_cnt_ff;
   logic signed [PROD_WIDTH-1:0] s3_prod_ff [NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_in    [NUM_AXES];

   coord_type [NUM_AXES-1:0] s4_pos_ff;
   coord_type [NUM_AXES-1:0] s4_vel_ff;
   logic [CNT_WIDTH-1:0]     s4_cnt_ff;
   logic signed [STEP_WIDTH-1:0] s4_step_ff [NUM_AXES];
   logic signed [STEP_WIDTH-1:0] step_in    [NUM_AXES];

   logic [GT_WIDTH:0]            g_sum;
   logic [G_WIDTH-1:0]           g_step;
   logic signed [WIDE_WIDTH-1:0] vz_wide;

   logic signed [WIDE_WIDTH-1:0] pos_sum  [NUM_AXES];
   logic signed [WIDE_WIDTH-1:0] wall_lim [NUM_AXES];
   logic [NUM_AXES-1:0]          wall_lo;
   logic [NUM_AXES-1:0]          wall_hi;

   // hold every stage while the last one waits on a full queue
   assign front_adv  = !s4_valid_ff || !q_full;
   assign req_stall  = !front_adv;
   assign push_valid = s4_valid_ff;

   assign gt_in = GT_WIDTH'(cfg.gravity) * GT_WIDTH'(cfg.time_step);

   // gravity step on vertical velocity
   always_comb begin
      g_sum     = {1'b0, s1_gt_ff} + (GT_WIDTH + 1)'(2 ** (FRAC_BITS - 1));
      g_step    = g_sum[GT_WIDTH:FRAC_BITS];
      vz_wide   = WIDE_WIDTH'(s1_req_ff.vel_z) - $signed(WIDE_WIDTH'(g_step));
      s2_vel_in[AXIS_X] = s1_req_ff.vel_x;
      s2_vel_in[AXIS_Y] = s1_req_ff.vel_y;
      s2_vel_in[AXIS_Z] = sat_coord(vz_wide);
   end

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         prod_in[k] = PROD_WIDTH'($signed(s2_vel_ff[k]))
                    * PROD_WIDTH'($signed({1'b0, cfg.time_step}));
         step_in[k] = STEP_WIDTH'(rnd_frac(s3_prod_ff[k]));
      end
   end

   // move, clamp to the walls, classify hits
   always_comb begin
      push_data.vel = s4_vel_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         pos_sum[k]  = WIDE_WIDTH'($signed(s4_pos_ff[k])) + WIDE_WIDTH'(s4_step_ff[k]);
         wall_lim[k] = (k == AXIS_Z) ? $signed(WIDE_WIDTH'(cfg.z_bound)) : WALL_UNIT;
         wall_lo[k]  = pos_sum[k] < -wall_lim[k];
         wall_hi[k]  = pos_sum[k] > wall_lim[k];
         if (wall_lo[k]) begin
            push_data.pos[k] = sat_coord(-wall_lim[k]);
         end else if (wall_hi[k]) begin
            push_data.pos[k] = sat_coord(wall_lim[k]);
         end else begin
            push_data.pos[k] = sat_coord(pos_sum[k]);
         end
      end
      push_data.hit = wall_lo | wall_hi;
      // only the floor costs a bounce, and the count stops at zero
      if (wall_lo[AXIS_Z] && s4_cnt_ff != '0) begin
         push_data.count = s4_cnt_ff - CNT_WIDTH'(1);
      end else begin
         push_data.count = s4_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (front_adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         s1_req_ff <= req_data;
         s1_gt_ff  <= gt_in;

         s2_pos_ff[AXIS_X] <= s1_req_ff.pos_x;
         s2_pos_ff[AXIS_Y] <= s1_req_ff.pos_y;
         s2_pos_ff[AXIS_Z] <= s1_req_ff.pos_z;
         s2_vel_ff         <= s2_vel_in;
         s2_cnt_ff         <= s1_req_ff.bounces_left;

         s3_pos_ff <= s2_pos_ff;
         s3_vel_ff <= s2_vel_ff;
         s3_cnt_ff <= s2_cnt_ff;

         s4_pos_ff <= s3_pos_ff;
         s4_vel_ff <= s3_vel_ff;
         s4_cnt_ff <= s3_cnt_ff;

         for (int k = 0; k < NUM_AXES; k++) begin
            s3_prod_ff[k] <= prod_in[k];
            s4_step_ff[k] <= step_in[k];
         end
      end
   end

   a_x_inside_walls: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (WIDE_WIDTH'($signed(push_data.pos[AXIS_X])) <= WALL_UNIT)
                  && (WIDE_WIDTH'($signed(push_data.pos[AXIS_X])) >= -WALL_UNIT))
      else $error("x position left the walls after clamp");

   a_count_never_rises: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_data.count <= s4_cnt_ff)
      else $error("bounce count increased");

   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && q_full |=> s4_valid_ff && $stable(s4_pos_ff) && $stable(s4_vel_ff))
      else $error("front stage lost its particle while the queue was full");

endmodule

`default_nettype wire

// File: hw/rtl/pbi_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pbi_queue
   import pbi_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          pop_valid,
   output work_type      pop_data
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int FILL_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]  LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [FILL_WIDTH-1:0] FULL_FILL = FILL_WIDTH'(DEPTH);

   work_type mem_ff [DEPTH];

   logic [PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [FILL_WIDTH-1:0] fill_ff;
   logic                  do_push;
   logic                  do_pop;

   assign full      = fill_ff == FULL_FILL;
   assign pop_valid = fill_ff != '0;
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + FILL_WIDTH'(1);
            2'b01:   fill_ff <= fill_ff - FILL_WIDTH'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("queue fill beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> fill_ff == $past(fill_ff) + FILL_WIDTH'(1))
      else $error("queue fill did not follow a push");

endmodule

`default_nettype wire

// File: hw/rtl/pbi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pbi_back
   import pbi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire work_type               q_data,
   output logic                        q_pop,
   input  wire logic [REST_WIDTH-1:0]  restitution,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   rsp_stall
);

   // one round per wall, in the order x, y, z
   localparam int ROUNDS = NUM_AXES;

   logic back_adv;

   logic [ROUNDS-1:0] rin_valid;
   logic [ROUNDS-1:0] a_valid_ff;
   logic [ROUNDS-1:0] b_valid_ff;

   work_type rin_item  [ROUNDS];
   work_type a_item_ff [ROUNDS];
   work_type b_item_ff [ROUNDS];
   work_type b_item_in [ROUNDS];

   logic signed [PROD_WIDTH-1:0] prod_in   [ROUNDS][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] a_prod_ff [ROUNDS][NUM_AXES];

   logic signed [PROD_WIDTH-1:0] rnd_val;
   logic signed [WIDE_WIDTH-1:0] scaled;

   // the last round's register is the output register
   assign back_adv  = !b_valid_ff[ROUNDS-1] || !rsp_stall;
   assign q_pop     = q_valid && back_adv;
   assign rsp_valid = b_valid_ff[ROUNDS-1];

   always_comb begin
      rin_valid[0] = q_valid;
      rin_item[0]  = q_data;
      for (int r = 1; r < ROUNDS; r++) begin
         rin_valid[r] = b_valid_ff[r-1];
         rin_item[r]  = b_item_ff[r-1];
      end
   end

   always_comb begin
      for (int r = 0; r < ROUNDS; r++) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            prod_in[r][k] = PROD_WIDTH'($signed(rin_item[r].vel[k]))
                          * PROD_WIDTH'($signed({1'b0, restitution}));
         end
      end
   end

   // scale all three components, negate the one that hit
   always_comb begin
      rnd_val = '0;
      scaled  = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         b_item_in[r] = a_item_ff[r];
         if (a_item_ff[r].hit[r]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               rnd_val = rnd_frac(a_prod_ff[r][k]);
               scaled  = WIDE_WIDTH'(rnd_val);
               if (k == r) begin
                  scaled = -scaled;
               end
               b_item_in[r].vel[k] = sat_coord(scaled);
            end
         end
      end
   end

   always_comb begin
      rsp_data.new_pos_x        = b_item_ff[ROUNDS-1].pos[AXIS_X];
      rsp_data.new_pos_y        = b_item_ff[ROUNDS-1].pos[AXIS_Y];
      rsp_data.new_pos_z        = b_item_ff[ROUNDS-1].pos[AXIS_Z];
      rsp_data.new_vel_x        = b_item_ff[ROUNDS-1].vel[AXIS_X];
      rsp_data.new_vel_y        = b_item_ff[ROUNDS-1].vel[AXIS_Y];
      rsp_data.new_vel_z        = b_item_ff[ROUNDS-1].vel[AXIS_Z];
      rsp_data.new_bounces_left = b_item_ff[ROUNDS-1].count;
      rsp_data.alive            = b_item_ff[ROUNDS-1].count != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= '0;
         b_valid_ff <= '0;
      end else if (back_adv) begin
         a_valid_ff <= rin_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         for (int r = 0; r < ROUNDS; r++) begin
            a_item_ff[r] <= rin_item[r];
            b_item_ff[r] <= b_item_in[r];
            for (int k = 0; k < NUM_AXES; k++) begin
               a_prod_ff[r][k] <= prod_in[r][k];
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/particle_bounce_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Port group   Direction  Handshake             Transaction
// req_*        in         req_valid/req_stall   one particle: position, velocity, bounces
// rsp_*        out        rsp_valid/rsp_stall   one updated particle with alive flag
// csr_*        in         csr_we                one register write, index csr_addr
//
// Throughput is one transaction per cycle while req_stall and rsp_stall stay low.
// From the req accepting edge to rsp_valid a particle passes four front stages
// (the first loaded by that edge), the queue, and six bounce stages.
// Reset empties the pipelines and the queue and loads the register defaults.
// A stall on rsp holds the bounce pipeline; the queue then absorbs up to
// QUEUE_DEPTH transactions before req_stall rises.

module particle_bounce_integrator_core
   import pbi_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   input  wire req_type                    req_data,
   output logic                            req_stall,

   output logic                            rsp_valid,
   output rsp_type                         rsp_data,
   input  wire logic                       rsp_stall,

   input  wire logic                       csr_we,
   input  wire logic [CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type  cfg_ff;

   logic     push_valid;
   work_type push_data;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   work_type q_data;

   // Registers must change only while no transaction is in flight (the block
   // itself does not enforce this), so every stage reads them directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TIME_STEP:   cfg_ff.time_step   <= csr_wdata[TS_WIDTH-1:0];
            CSR_GRAVITY:     cfg_ff.gravity     <= csr_wdata[GRAV_WIDTH-1:0];
            CSR_RESTITUTION: cfg_ff.restitution <= csr_wdata[REST_WIDTH-1:0];
            CSR_Z_BOUND:     cfg_ff.z_bound     <= csr_wdata[ZB_WIDTH-1:0];
         endcase
      end
   end

   // Front: apply gravity, integrate, clamp to the box, classify wall hits.
   pbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   // Decouple the two halves so each can stall without draining the other.
   pbi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   // Back: three restitution rounds (x, y, z walls), then drive rsp.
   pbi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .restitution (cfg_ff.restitution),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

// File: tb/particle_bounce_integrator_core_tb.sv
`timescale 1ns / 1ps

module particle_bounce_integrator_core_tb;
   import pbi_pkg::*;

   // Signed Q7.16 limits and the unit wall of the x and y axes
   localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint Q_ONE     = 64'sd1 <<< FRAC_BITS;
   localparam longint Q_HALF    = 64'sd1 <<< (FRAC_BITS - 1);

   // Leave margin after the pipeline drains before touching registers
   localparam int DRAIN_CYCLES    = 24;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } launch_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;
   logic    csr_we;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   // Hand-computed expectation that travels with the particle on the bus
   bit      row_typed;
   rsp_type row_want;

   cfg_type        shadow_settings;
   rsp_type        expected_particles[$];
   launch_row_type launch_table[$];
   int             mismatches;

   // Idle control shared by the sender and the receiver
   bit calm;
   bit hold_off_request;
   bit stall_held;

   particle_bounce_integrator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("particle_bounce_integrator_core_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic longint clip_coord(input longint x);
      if (x > COORD_MAX) begin
         return COORD_MAX;
      end else if (x < COORD_MIN) begin
         return COORD_MIN;
      end
      return x;
   endfunction

   // Round half up to 16 fraction bits; arithmetic shift floors negatives
   function automatic longint round_q16(input longint x);
      return (x + Q_HALF) >>> FRAC_BITS;
   endfunction

   function automatic rsp_type integrate_particle(input req_type p);
      longint      pos [NUM_AXES];
      longint      vel [NUM_AXES];
      longint      wall [NUM_AXES];
      longint      ts;
      longint      rest;
      bit          hit;
      int unsigned cnt;
      rsp_type     r;
      ts      = longint'(shadow_settings.time_step);
      rest    = longint'(shadow_settings.restitution);
      pos[0]  = p.pos_x;
      pos[1]  = p.pos_y;
      pos[2]  = p.pos_z;
      vel[0]  = p.vel_x;
      vel[1]  = p.vel_y;
      vel[2]  = p.vel_z;
      wall[0] = Q_ONE;
      wall[1] = Q_ONE;
      wall[2] = longint'(shadow_settings.z_bound);
      cnt     = p.bounces_left;

      // Gravity pulls the vertical velocity down, then every axis moves
      vel[AXIS_Z] = clip_coord(vel[AXIS_Z]
                               - round_q16(longint'(shadow_settings.gravity) * ts));
      for (int a = 0; a < NUM_AXES; a++) begin
         pos[a] = pos[a] + round_q16(vel[a] * ts);
      end

      // Walls in x, y, z order, each one seeing the velocity left by the last
      for (int a = 0; a < NUM_AXES; a++) begin
         hit = 1'b0;
         if (pos[a] < -wall[a]) begin
            pos[a] = -wall[a];
            hit    = 1'b1;
            if (a == AXIS_Z && cnt != 0) begin
               cnt--;
            end
         end else if (pos[a] > wall[a]) begin
            pos[a] = wall[a];
            hit    = 1'b1;
         end
         if (hit) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               vel[k] = clip_coord(round_q16(vel[k] * rest));
               if (k == a) begin
                  vel[k] = clip_coord(-vel[k]);
               end
            end
         end
      end

      r.new_pos_x        = coord_type'(clip_coord(pos[0]));
      r.new_pos_y        = coord_type'(clip_coord(pos[1]));
      r.new_pos_z        = coord_type'(clip_coord(pos[2]));
      r.new_vel_x        = coord_type'(vel[0]);
      r.new_vel_y        = coord_type'(vel[1]);
      r.new_vel_z        = coord_type'(vel[2]);
      r.new_bounces_left = CNT_WIDTH'(cnt);
      r.alive            = (cnt != 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   function automatic req_type make_req(input longint px, input longint py,
                                        input longint pz, input longint vx,
                                        input longint vy, input longint vz,
                                        input int b);
      req_type p;
      p.pos_x        = coord_type'(px);
      p.pos_y        = coord_type'(py);
      p.pos_z        = coord_type'(pz);
      p.vel_x        = coord_type'(vx);
      p.vel_y        = coord_type'(vy);
      p.vel_z        = coord_type'(vz);
      p.bounces_left = CNT_WIDTH'(b);
      return p;
   endfunction

   function automatic rsp_type make_rsp(input longint px, input longint py,
                                        input longint pz, input longint vx,
                                        input longint vy, input longint vz,
                                        input int b, input bit live);
      rsp_type r;
      r.new_pos_x        = coord_type'(px);
      r.new_pos_y        = coord_type'(py);
      r.new_pos_z        = coord_type'(pz);
      r.new_vel_x        = coord_type'(vx);
      r.new_vel_y        = coord_type'(vy);
      r.new_vel_z        = coord_type'(vz);
      r.new_bounces_left = CNT_WIDTH'(b);
      r.alive            = live;
      return r;
   endfunction

   // Append one directed row to the stimulus table
   function automatic void add_row(input req_type item, input bit typed,
                                   input rsp_type want);
      launch_row_type row;
      row.item  = item;
      row.typed = typed;
      row.want  = want;
      launch_table.insert(launch_table.size(), row);
   endfunction

   // Mostly close to a wall, otherwise anywhere inside the box
   function automatic coord_type pick_position(input longint wall);
      longint spot;
      case ($urandom_range(0, 2))
         0: spot = wall + longint'($urandom_range(0, 8192)) - 4096;
         1: spot = -wall + longint'($urandom_range(0, 8192)) - 4096;
         default: spot = longint'($urandom_range(0, int'(2 * wall))) - wall;
      endcase
      return coord_type'(clip_coord(spot));
   endfunction

   function automatic coord_type pick_velocity();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom);
         1: return coord_type'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return coord_type'($urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
         default: return coord_type'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
      endcase
   endfunction

   function automatic req_type random_particle();
      req_type p;
      if ($urandom_range(0, 3) == 0) begin
         // Raw noise: every bit of every field free
         p.pos_x        = coord_type'($urandom);
         p.pos_y        = coord_type'($urandom);
         p.pos_z        = coord_type'($urandom);
         p.vel_x        = coord_type'($urandom);
         p.vel_y        = coord_type'($urandom);
         p.vel_z        = coord_type'($urandom);
         p.bounces_left = CNT_WIDTH'($urandom);
      end else begin
         p.pos_x        = pick_position(Q_ONE);
         p.pos_y        = pick_position(Q_ONE);
         p.pos_z        = pick_position(longint'(shadow_settings.z_bound));
         p.vel_x        = pick_velocity();
         p.vel_y        = pick_velocity();
         p.vel_z        = pick_velocity();
         p.bounces_left = $urandom_range(0, 1) ? CNT_WIDTH'($urandom_range(0, 3))
                                               : CNT_WIDTH'($urandom);
      end
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Driving (all changes at the falling edge)
   // ---------------------------------------------------------------------

   // Offer one transaction and hold it until accepted; leave valid high
   task automatic launch_particle(input req_type item, input bit typed,
                                  input rsp_type want);
      if (!calm && !hold_off_request && !stall_held && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      row_typed <= typed;
      row_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int count);
      for (int i = 0; i < count; i++) begin
         launch_particle(random_particle(), 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // Drain, then write all four registers on back-to-back cycles
   task automatic apply_settings(input cfg_type c);
      while (expected_particles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TIME_STEP;
      csr_wdata <= CSR_DATA_WIDTH'(c.time_step);
      @(negedge clock);
      csr_addr  <= CSR_GRAVITY;
      csr_wdata <= CSR_DATA_WIDTH'(c.gravity);
      @(negedge clock);
      csr_addr  <= CSR_RESTITUTION;
      csr_wdata <= CSR_DATA_WIDTH'(c.restitution);
      @(negedge clock);
      csr_addr  <= CSR_Z_BOUND;
      csr_wdata <= CSR_DATA_WIDTH'(c.z_bound);
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_settings = c;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request
   // ---------------------------------------------------------------------

   initial begin
      rsp_stall  = 1'b0;
      stall_held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            // Hold long enough for the queue to fill and req_stall to rise
            hold_off_request = 1'b0;
            stall_held       = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            stall_held       = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checking (sampled at the rising edge)
   // ---------------------------------------------------------------------

   task automatic check_particle(input rsp_type got, input rsp_type want);
      if (got.new_pos_x !== want.new_pos_x) begin
         $error("new_pos_x: expected %0d, got %0d", want.new_pos_x, got.new_pos_x);
         mismatches++;
      end
      if (got.new_pos_y !== want.new_pos_y) begin
         $error("new_pos_y: expected %0d, got %0d", want.new_pos_y, got.new_pos_y);
         mismatches++;
      end
      if (got.new_pos_z !== want.new_pos_z) begin
         $error("new_pos_z: expected %0d, got %0d", want.new_pos_z, got.new_pos_z);
         mismatches++;
      end
      if (got.new_vel_x !== want.new_vel_x) begin
         $error("new_vel_x: expected %0d, got %0d", want.new_vel_x, got.new_vel_x);
         mismatches++;
      end
      if (got.new_vel_y !== want.new_vel_y) begin
         $error("new_vel_y: expected %0d, got %0d", want.new_vel_y, got.new_vel_y);
         mismatches++;
      end
      if (got.new_vel_z !== want.new_vel_z) begin
         $error("new_vel_z: expected %0d, got %0d", want.new_vel_z, got.new_vel_z);
         mismatches++;
      end
      if (got.new_bounces_left !== want.new_bounces_left) begin
         $error("new_bounces_left: expected %0d, got %0d",
                want.new_bounces_left, got.new_bounces_left);
         mismatches++;
      end
      if (got.alive !== want.alive) begin
         $error("alive: expected %0d, got %0d", want.alive, got.alive);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // Queue the expectation for every accepted particle
         if (req_valid && !req_stall) begin
            if (row_typed) begin
               expected_particles.insert(expected_particles.size(), row_want);
            end else begin
               expected_particles.insert(expected_particles.size(),
                                         integrate_particle(req_data));
            end
         end
         // Pop and compare every accepted result
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_particles.size() == 0) begin
               $error("rsp: result with no particle outstanding");
               mismatches++;
            end else begin
               check_particle(rsp_data, expected_particles.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin : stimulus
      cfg_type   heavy;
      cfg_type   still;
      cfg_type   flat;
      cfg_type   mixed;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      row_typed        = 1'b0;
      row_want         = '0;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      calm             = 1'b0;
      hold_off_request = 1'b0;
      mismatches       = 0;
      shadow_settings  = CFG_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows under reset settings. Default gravity step is 10702
      // per frame, which moves a resting particle down by 178.
      add_row(make_req(0, 0, 0, 0, 0, 0, 5), 1'b1,
              make_rsp(0, 0, -178, 0, 0, -10702, 5, 1'b1));
      // Entering with zero bounces: computed values, but dead
      add_row(make_req(0, 0, 0, 0, 0, 0, 0), 1'b1,
              make_rsp(0, 0, -178, 0, 0, -10702, 0, 1'b0));
      // Resting on the floor: clamp, scale by 0.8, flip, lose one bounce
      add_row(make_req(0, 0, -Q_ONE, 0, 0, 0, 3), 1'b1,
              make_rsp(0, 0, -Q_ONE, 0, 0, 8562, 2, 1'b1));
      // Floor hit with zero bounces left: count holds at zero
      add_row(make_req(0, 0, -Q_ONE, 0, 0, 0, 0), 1'b1,
              make_rsp(0, 0, -Q_ONE, 0, 0, 8562, 0, 1'b0));
      // Ceiling, side walls, all walls at once, range extremes
      add_row(make_req(0, 0, Q_ONE, 0, 0, COORD_MAX, 7), 1'b0, '0);
      add_row(make_req(Q_ONE, 0, 0, COORD_MAX, 1000, -1000, 9), 1'b0, '0);
      add_row(make_req(-Q_ONE, 0, 0, COORD_MIN, -3000, 3000, 9), 1'b0, '0);
      add_row(make_req(0, Q_ONE, 0, 5000, COORD_MAX, 0, 4), 1'b0, '0);
      add_row(make_req(0, -Q_ONE, 0, -5000, COORD_MIN, 0, 4), 1'b0, '0);
      add_row(make_req(Q_ONE, -Q_ONE, -Q_ONE, COORD_MAX,
                       COORD_MIN, COORD_MIN, 1), 1'b0, '0);
      add_row(make_req(COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX, COORD_MAX, COORD_MAX, 255), 1'b0, '0);
      add_row(make_req(COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MIN, COORD_MIN, COORD_MIN, 255), 1'b0, '0);
      // Gravity pushes an already minimal vertical velocity into saturation
      add_row(make_req(0, 0, 0, 0, 0, COORD_MIN, 2), 1'b0, '0);
      add_row(make_req(COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 0), 1'b0, '0);
      // Last bounce used up on the floor
      add_row(make_req(0, 0, -Q_ONE, 0, 0, -Q_ONE, 1), 1'b0, '0);
      // Just inside every wall
      add_row(make_req(Q_ONE - 1, -(Q_ONE - 1), Q_ONE - 1, 0, 0, 0, 6), 1'b0, '0);
      // Small values exercise rounding on both signs
      add_row(make_req(0, 0, 0, 1, -1, 32768, 128), 1'b0, '0);
      add_row(make_req(-1, -1, -1, -1, -1, -1, 170), 1'b0, '0);

      foreach (launch_table[i]) begin
         launch_particle(launch_table[i].item, launch_table[i].typed, launch_table[i].want);
      end

      // Random phases, one register setting each
      run_phase(100);

      heavy = '{time_step: 16'hFFFF, gravity: 23'h7FFFFF,
                restitution: 16'hFFFF, z_bound: 23'h7FFFFF};
      apply_settings(heavy);
      run_phase(105);

      still = '{time_step: '0, gravity: '0, restitution: '0, z_bound: '0};
      apply_settings(still);
      run_phase(105);

      // Long frames in a flat box: nearly every particle hits a z wall
      flat = '{time_step: 16'hFFFF, gravity: '0, restitution: '0, z_bound: '0};
      apply_settings(flat);
      run_phase(105);

      mixed.time_step   = TS_WIDTH'($urandom);
      mixed.gravity     = GRAV_WIDTH'($urandom);
      mixed.restitution = REST_WIDTH'($urandom_range(32768, 65535));
      mixed.z_bound     = ZB_WIDTH'($urandom_range(0, 4 * 65536));
      apply_settings(mixed);
      // Back-pressure: receiver holds off while the sender keeps offering
      hold_off_request = 1'b1;
      run_phase(105);

      apply_settings(CFG_RESET);
      run_phase(50);
      // Drop all idling for the tail of the run
      calm = 1'b1;
      @(negedge clock);
      run_phase(60);

      while (expected_particles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("particle_bounce_integrator_core_tb: done, clean");
      end else begin
         $display("particle_bounce_integrator_core_tb: done, errors");
      end
      $finish;
   end

endmodule
